### src/dtti_pkg.sv
// ----------------------------------------------------------------------------
// dtti_pkg: shared types and constants of the decimal text parser
// Holds the classified character item, the configuration bundle and the
// codes used across the front, queue and back modules.
// ----------------------------------------------------------------------------
package dtti_pkg;

  // Fixed field widths of the channels.
  localparam int CHAR_BITS     = 8;
  localparam int VALUE_BITS    = 64;
  localparam int STATUS_BITS   = 2;
  localparam int CONSUMED_OUT  = 16;
  localparam int DIGIT_CNT_BITS = 5;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDE_MODE   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIGNED_MODE = 1'd1;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NO_DIGITS = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_TOO_MANY  = 2'd2;

  // Digit limits per mode.
  localparam logic [DIGIT_CNT_BITS-1:0] LIM_32     = 5'd10;
  localparam logic [DIGIT_CNT_BITS-1:0] LIM_S64    = 5'd19;
  localparam logic [DIGIT_CNT_BITS-1:0] LIM_U64    = 5'd20;

  // Characters of interest.
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;

  // One classified character.
  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 is_ws;
    logic                 is_minus;
    logic                 is_digit;
    logic [3:0]           digit;
  } dtti_item_t;

  // Configuration bundle.
  typedef struct packed {
    logic wide_mode;
    logic signed_mode;
  } dtti_cfg_t;

endpackage

### src/dtti_front.sv
// ----------------------------------------------------------------------------
// dtti_front: character classifier
// Accepts characters and tags each one as whitespace, minus or digit
// before it enters the queue.
// ----------------------------------------------------------------------------
module dtti_front import dtti_pkg::*; (
  input  logic [CHAR_BITS-1:0] char_in,
  output dtti_item_t           item
);

  // Classify the character. Digits sit at 0x30 to 0x39, so the low nibble
  // of a digit is its value.
  always_comb begin
    item.ch       = char_in;
    item.is_ws    = (char_in == CH_TAB) || (char_in == CH_LF) || (char_in == CH_SPACE);
    item.is_minus = (char_in == CH_MINUS);
    item.is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    item.digit    = char_in[3:0];
  end

endmodule

### src/dtti_queue.sv
// ----------------------------------------------------------------------------
// dtti_queue: short first-word-fall-through queue
// Decouples the classifier from the parser so that each side stalls on
// its own.
// ----------------------------------------------------------------------------
module dtti_queue import dtti_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  dtti_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output dtti_item_t head
);

  localparam logic [QPTR_BITS:0] DEPTH_CNT = (QPTR_BITS + 1)'(QUEUE_DEPTH);

  dtti_item_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]   count_r, count_nxt;

  assign full  = (count_r == DEPTH_CNT);
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  // Pointer and fill updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_BITS'(push);
    rd_ptr_nxt = rd_ptr_r + QPTR_BITS'(pop);
    count_nxt  = count_r + (QPTR_BITS + 1)'(push) - (QPTR_BITS + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### src/dtti_back.sv
// ----------------------------------------------------------------------------
// dtti_back: parse engine with result register
// Runs the skip, sign and digit phases on each classified character and
// holds a finished result until its transfer.
// ----------------------------------------------------------------------------
module dtti_back import dtti_pkg::*; #(
  parameter int CONSUMED_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dtti_cfg_t               cfg,
  input  logic                    q_empty,
  input  dtti_item_t              q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [VALUE_BITS-1:0]   out_value_bits,
  output logic [STATUS_BITS-1:0]  out_status,
  output logic [CONSUMED_OUT-1:0] out_chars_consumed,
  output logic [CHAR_BITS-1:0]    out_terminator
);

  localparam logic PH_SKIP   = 1'b0;
  localparam logic PH_DIGITS = 1'b1;
  localparam int   EXT_BITS  = (CONSUMED_BITS > CONSUMED_OUT) ? CONSUMED_BITS : CONSUMED_OUT;

  logic                      phase_r, phase_nxt;
  logic [VALUE_BITS-1:0]     acc_r, acc_nxt;
  logic [DIGIT_CNT_BITS-1:0] dcnt_r, dcnt_nxt;
  logic                      minus_r, minus_nxt;
  logic [CONSUMED_BITS-1:0]  cons_r, cons_nxt, cons_bump;
  logic                      out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0]     value_r;
  logic [STATUS_BITS-1:0]    status_r;
  logic [CONSUMED_OUT-1:0]   consumed_r;
  logic [CHAR_BITS-1:0]      term_r;

  logic                      step;
  logic                      emit;
  logic [VALUE_BITS-1:0]     emit_value;
  logic [STATUS_BITS-1:0]    emit_status;
  logic [DIGIT_CNT_BITS-1:0] limit;
  logic [VALUE_BITS-1:0]     acc_times10;
  logic [VALUE_BITS-1:0]     signed_acc;
  logic [VALUE_BITS-1:0]     finish_val;
  logic [EXT_BITS-1:0]       cons_ext;
  logic [CONSUMED_OUT-1:0]   cons_sat;

  // A character is taken whenever the result register is free or draining.
  assign step  = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop = step;

  // Digit limit, saturating count and final value shaping.
  always_comb begin
    if (cfg.wide_mode) begin
      limit = cfg.signed_mode ? LIM_S64 : LIM_U64;
    end else begin
      limit = LIM_32;
    end
    cons_bump   = (cons_r == '1) ? cons_r : cons_r + CONSUMED_BITS'(1);
    cons_ext    = EXT_BITS'(cons_r);
    cons_sat    = (cons_ext > EXT_BITS'({CONSUMED_OUT{1'b1}})) ? {CONSUMED_OUT{1'b1}}
                                                               : cons_ext[CONSUMED_OUT-1:0];
    acc_times10 = {acc_r[VALUE_BITS-4:0], 3'b000} + {acc_r[VALUE_BITS-2:0], 1'b0};
    signed_acc  = minus_r ? (VALUE_BITS'(0) - acc_r) : acc_r;
    if (cfg.wide_mode) begin
      finish_val = signed_acc;
    end else begin
      finish_val = {{32{cfg.signed_mode & signed_acc[31]}}, signed_acc[31:0]};
    end
  end

  // Parse step for the character at the head of the queue.
  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    dcnt_nxt    = dcnt_r;
    minus_nxt   = minus_r;
    cons_nxt    = cons_r;
    emit        = 1'b0;
    emit_value  = '0;
    emit_status = ST_OK;
    if (phase_r == PH_SKIP && q_head.is_ws) begin
      cons_nxt = cons_bump;
    end else if (phase_r == PH_SKIP && q_head.is_minus && cfg.signed_mode) begin
      minus_nxt = 1'b1;
      cons_nxt  = cons_bump;
      phase_nxt = PH_DIGITS;
    end else if (q_head.is_digit) begin
      if (dcnt_r >= limit) begin
        emit        = 1'b1;
        emit_status = ST_TOO_MANY;
      end else begin
        dcnt_nxt  = dcnt_r + DIGIT_CNT_BITS'(1);
        acc_nxt   = acc_times10 + VALUE_BITS'(q_head.digit);
        cons_nxt  = cons_bump;
        phase_nxt = PH_DIGITS;
      end
    end else if (dcnt_r == '0) begin
      emit        = 1'b1;
      emit_status = ST_NO_DIGITS;
    end else begin
      emit        = 1'b1;
      emit_value  = finish_val;
      emit_status = ST_OK;
    end
    // A finished parse starts over.
    if (emit) begin
      phase_nxt = PH_SKIP;
      acc_nxt   = '0;
      dcnt_nxt  = '0;
      minus_nxt = 1'b0;
      cons_nxt  = '0;
    end
  end

  // Result valid: set on an emitting step, cleared once the transfer is done.
  always_comb begin
    if (step && emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Parse state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SKIP;
      acc_r       <= '0;
      dcnt_r      <= '0;
      minus_r     <= 1'b0;
      cons_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        dcnt_r  <= dcnt_nxt;
        minus_r <= minus_nxt;
        cons_r  <= cons_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (step && emit) begin
      value_r    <= emit_value;
      status_r   <= emit_status;
      consumed_r <= cons_sat;
      term_r     <= q_head.ch;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_value_bits     = value_r;
  assign out_status         = status_r;
  assign out_chars_consumed = consumed_r;
  assign out_terminator     = term_r;

endmodule

### src/decimal_text_to_integer_top.sv
// ----------------------------------------------------------------------------
// decimal_text_to_integer_top: streaming ASCII decimal parser
// Parses one decimal integer per run of characters, one character a cycle while in_stall is low.
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_stall   in_char_in
//   out      output     out_valid/out_stall out_value_bits, out_status,
//                                           out_chars_consumed, out_terminator
//   cfg      input      cfg_we              cfg_index, cfg_data
//
// One character is taken per cycle while the queue is not full; the parse
// step is one multiply-by-ten add in the back stage, which sets the rate. A
// result becomes valid after its terminator passes the queue: the terminator
// is first written into the queue and the result register loads as it leaves.
// Reset is synchronous and clears the parse state, the queue and the
// configuration (wide_mode 0, signed_mode 1). A stall on the result side
// fills the two-entry queue before in_stall rises.
// ----------------------------------------------------------------------------
module decimal_text_to_integer_top import dtti_pkg::*; #(
  parameter int CONSUMED_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CHAR_BITS-1:0]     in_char_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [VALUE_BITS-1:0]    out_value_bits,
  output logic [STATUS_BITS-1:0]   out_status,
  output logic [CONSUMED_OUT-1:0]  out_chars_consumed,
  output logic [CHAR_BITS-1:0]     out_terminator,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  dtti_cfg_t  cfg_r;
  dtti_item_t front_item;
  dtti_item_t q_head;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  logic       q_push;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wide_mode   <= 1'b0;
      cfg_r.signed_mode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDE_MODE:   cfg_r.wide_mode   <= cfg_data[0];
        CFG_SIGNED_MODE: cfg_r.signed_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Input transfer goes straight into the queue.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  dtti_front u_front (
    .char_in (in_char_in),
    .item    (front_item)
  );

  dtti_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  dtti_back #(
    .CONSUMED_BITS (CONSUMED_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_value_bits     (out_value_bits),
    .out_status         (out_status),
    .out_chars_consumed (out_chars_consumed),
    .out_terminator     (out_terminator)
  );

endmodule
